>>> design/lcfg_pkg.sv
// Shared types, constants and color tables for the lamp color frame generator.
`default_nettype none

package lcfg_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned RangeW  = 16;
  localparam int unsigned DistW   = 16;
  localparam int unsigned LightW  = 12;
  localparam int unsigned SelW    = 3;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Brightness is light * 255 / 4095. Since 4095 is 2^12 - 1, x / 4095 equals
  // (x + (x >> 12) + 1) >> 12 for every product x that can occur here.
  localparam int unsigned ProdW     = LightW + ChanW;
  localparam int unsigned FoldShift = LightW;
  localparam int unsigned QuoW      = ChanW;

  localparam logic [ChanW-1:0]  BreathInc    = ChanW'(3);
  localparam logic [ChanW-1:0]  BreathTop    = ChanW'(252);
  localparam logic [PhaseW-1:0] PhaseLast    = PhaseW'(13);

  localparam logic [RangeW-1:0] NightRangeRst = RangeW'(200);
  localparam logic [RangeW-1:0] StudyRangeRst = RangeW'(120);

  typedef enum logic [ModeW-1:0] {
    ModeNormal = 3'd0,
    ModeCold   = 3'd1,
    ModeWarm   = 3'd2,
    ModeBreath = 3'd3,
    ModeNight  = 3'd4,
    ModeStudy  = 3'd5,
    ModeAuto   = 3'd6
  } lamp_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode  = 2'd0,
    CfgLevel = 2'd1,
    CfgNight = 2'd2,
    CfgStudy = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StScale = 2'd1,
    StHold  = 2'd2
  } lcfg_state_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  // Channel enable mask: bit 0 red, bit 1 green, bit 2 blue.
  typedef logic [2:0] chan_mask_t;

  localparam rgb_t DimNormal = '{r: 8'h44, g: 8'h44, b: 8'h11};
  localparam rgb_t Black     = '{r: 8'h00, g: 8'h00, b: 8'h00};

  function automatic rgb_t static_color(input logic [ModeW-1:0] mode,
                                        input logic [LevelW-1:0] level);
    rgb_t c;
    c = Black;
    case (mode)
      ModeNormal: begin
        case (level)
          3'd1: c = '{r: 8'h44, g: 8'h44, b: 8'h11};
          3'd2: c = '{r: 8'h77, g: 8'h77, b: 8'h11};
          3'd3: c = '{r: 8'hBB, g: 8'hBB, b: 8'h11};
          3'd4: c = '{r: 8'hEE, g: 8'hEE, b: 8'h00};
          default: c = Black;
        endcase
      end
      ModeCold: begin
        case (level)
          3'd1: c = '{r: 8'h55, g: 8'h55, b: 8'h99};
          3'd2: c = '{r: 8'h77, g: 8'h77, b: 8'hBB};
          3'd3: c = '{r: 8'h99, g: 8'h99, b: 8'hDD};
          3'd4: c = '{r: 8'hBB, g: 8'hBB, b: 8'hFF};
          default: c = Black;
        endcase
      end
      ModeWarm: begin
        case (level)
          3'd1: c = '{r: 8'h33, g: 8'h33, b: 8'h44};
          3'd2: c = '{r: 8'h44, g: 8'h44, b: 8'h77};
          3'd3: c = '{r: 8'hAA, g: 8'hAA, b: 8'h88};
          3'd4: c = '{r: 8'hEE, g: 8'hEE, b: 8'hFF};
          default: c = Black;
        endcase
      end
      default: c = Black;
    endcase
    return c;
  endfunction

  function automatic chan_mask_t phase_mask(input logic [PhaseW-2:0] pair);
    chan_mask_t m;
    case (pair)
      3'd0: m = 3'b010;
      3'd1: m = 3'b001;
      3'd2: m = 3'b100;
      3'd3: m = 3'b011;
      3'd4: m = 3'b110;
      3'd5: m = 3'b101;
      3'd6: m = 3'b111;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // Palette entries are full-scale or zero per channel, so a mask says it all.
  function automatic chan_mask_t palette_mask(input logic [SelW-1:0] sel);
    chan_mask_t m;
    case (sel)
      3'd1: m = 3'b110;
      3'd2: m = 3'b011;
      3'd3: m = 3'b101;
      3'd4: m = 3'b100;
      3'd5: m = 3'b001;
      3'd6: m = 3'b010;
      default: m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/lcfg_scale_div.sv
// Brightness scaler that forms light * 255 / 4095 with one shared adder used in two passes.
`default_nettype none

module lcfg_scale_div
  import lcfg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [LightW-1:0] light_i,
  output logic                   done_o,
  output logic [QuoW-1:0]        quotient_o
);

  logic             busy_q, busy_d;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [ProdW-1:0] op_a, op_b;
  logic [ProdW-1:0] sum;

  // The first pass forms light * 256 - light. The second adds that value
  // shifted right by twelve plus one, which leaves the quotient in the top byte.
  always_comb begin
    if (start_i) begin
      op_a = {light_i, ChanW'(0)};
      op_b = ~ProdW'(light_i);
    end else begin
      op_a = acc_q;
      op_b = acc_q >> FoldShift;
    end
    sum    = op_a + op_b + ProdW'(1);
    busy_d = start_i;
    acc_d  = (start_i || busy_q) ? sum : acc_q;
    done_o = busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign quotient_o = acc_q[ProdW-1:FoldShift];

endmodule

`default_nettype wire

>>> design/lamp_color_frame_generator_unit.sv
// Top level of the lamp color frame generator: registers, sequencer and output stage.
`default_nettype none

// Each accepted beat is one frame tick and yields one color beat for the whole
// strip. A tick is accepted only while the unit is idle. The auto-mode brightness
// light * 255 / 4095 comes from one shared adder used twice: it forms light * 255
// in the accepting cycle and folds the high bits back in on the next cycle. The
// hold state moves the result into the output register once that is free, and no
// new tick is taken before then, so a stalled output holds off the next tick. In
// breathing mode the phase and level advance on each accepted tick. Configuration
// writes are taken at any time but must only be made while the unit is idle.

module lamp_color_frame_generator_unit
  import lcfg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [DistW-1:0]    distance_cm_i,
  input  wire logic [LightW-1:0]   light_level_i,
  input  wire logic [SelW-1:0]     color_select_i,
  input  wire logic                breath_restart_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ChanW-1:0]         red_o,
  output logic [ChanW-1:0]         green_o,
  output logic [ChanW-1:0]         blue_o,
  output logic                     refresh_o
);

  logic [ModeW-1:0]  mode_q;
  logic [LevelW-1:0] level_q;
  logic [RangeW-1:0] night_q;
  logic [RangeW-1:0] study_q;

  logic [ChanW-1:0]  blevel_q, blevel_d;
  logic [PhaseW-1:0] bphase_q, bphase_d;

  lcfg_state_e state_q, state_d;

  rgb_t        color_q, color_d;
  logic        refresh_q, refresh_d;
  logic        auto_q, auto_d;
  chan_mask_t  amask_q, amask_d;

  logic        out_valid_q, out_valid_d;
  rgb_t        out_color_q, out_color_d;
  logic        out_refresh_q, out_refresh_d;

  logic              in_accept;
  logic              out_free;
  logic              div_done;
  logic [QuoW-1:0]   div_quo;

  logic [ChanW-1:0]  lvl0, lvl1, bval;
  logic [PhaseW-1:0] ph0, ph1;
  chan_mask_t        bmask;
  rgb_t              scaled;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      level_q <= '0;
      night_q <= NightRangeRst;
      study_q <= StudyRangeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMode:  mode_q  <= cfg_data_i[ModeW-1:0];
        CfgLevel: level_q <= cfg_data_i[LevelW-1:0];
        CfgNight: night_q <= cfg_data_i[RangeW-1:0];
        CfgStudy: study_q <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  // Breathing step and the color chosen at acceptance.
  always_comb begin
    lvl0 = breath_restart_i ? '0 : blevel_q;
    ph0  = breath_restart_i ? '0 : bphase_q;
    lvl1 = lvl0 + BreathInc;
    ph1  = ph0;
    if (lvl1 >= BreathTop) begin
      ph1  = (ph0 >= PhaseLast) ? '0 : (ph0 + PhaseW'(1));
      lvl1 = '0;
    end
    bval  = ph1[0] ? ~lvl1 : lvl1;
    bmask = phase_mask(ph1[PhaseW-1:1]);

    color_d   = color_q;
    refresh_d = refresh_q;
    auto_d    = auto_q;
    amask_d   = amask_q;
    blevel_d  = blevel_q;
    bphase_d  = bphase_q;
    if (in_accept) begin
      blevel_d  = lvl0;
      bphase_d  = ph0;
      color_d   = Black;
      refresh_d = 1'b0;
      auto_d    = 1'b0;
      amask_d   = palette_mask(color_select_i);
      case (mode_q)
        ModeNormal, ModeCold, ModeWarm: begin
          color_d = static_color(mode_q, level_q);
        end
        ModeBreath: begin
          blevel_d  = lvl1;
          bphase_d  = ph1;
          color_d.r = bmask[0] ? bval : '0;
          color_d.g = bmask[1] ? bval : '0;
          color_d.b = bmask[2] ? bval : '0;
          refresh_d = 1'b1;
        end
        ModeNight: begin
          if ((distance_cm_i != '0) && (distance_cm_i <= night_q)) begin
            color_d = DimNormal;
          end
          refresh_d = 1'b1;
        end
        ModeStudy: begin
          if ((distance_cm_i != '0) && (distance_cm_i <= study_q)) begin
            color_d = DimNormal;
          end
          refresh_d = 1'b1;
        end
        ModeAuto: begin
          auto_d    = 1'b1;
          refresh_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    scaled.r = amask_q[0] ? div_quo : '0;
    scaled.g = amask_q[1] ? div_quo : '0;
    scaled.b = amask_q[2] ? div_quo : '0;

    state_d       = state_q;
    out_valid_d   = out_valid_q;
    out_color_d   = out_color_q;
    out_refresh_d = out_refresh_q;
    in_stall_o    = (state_q != StIdle);
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StScale;
        end
      end
      StScale: begin
        if (div_done) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_color_d   = auto_q ? scaled : color_q;
          out_refresh_d = refresh_q;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      blevel_q    <= '0;
      bphase_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      blevel_q    <= blevel_d;
      bphase_q    <= bphase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q       <= color_d;
    refresh_q     <= refresh_d;
    auto_q        <= auto_d;
    amask_q       <= amask_d;
    out_color_q   <= out_color_d;
    out_refresh_q <= out_refresh_d;
  end

  lcfg_scale_div u_scale_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .light_i    (light_level_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign red_o       = out_color_q.r;
  assign green_o     = out_color_q.g;
  assign blue_o      = out_color_q.b;
  assign refresh_o   = out_refresh_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StScale))
    else $error("accepted beat did not start the scaling sequence");

  a_done_only_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StScale))
    else $error("scaler finished outside the scaling state");

  a_hold_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StHold) && out_free) |=> (out_valid_q && (state_q == StIdle)))
    else $error("result was not moved to the output register");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bphase_q <= PhaseLast)
    else $error("breathing phase left its range");
`endif

endmodule

`default_nettype wire
